// File: rtl/bresenham_line_rasterizer_assert.svh
// Assertion macros for the line rasterizer.
`ifndef BRESENHAM_LINE_RASTERIZER_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define BLR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define BLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BLR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/blr_pkg.sv
// Types and constants shared by the line rasterizer modules.
`default_nettype none

package blr_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned DEC_BITS   = COORD_BITS + 3;
  localparam int unsigned INC_BITS   = COORD_BITS + 2;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e  kind;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last;
  } out_item_t;

  // Line set-up derived from a start transaction.
  typedef struct packed {
    logic                       steep;
    logic                       minor_down;
    coord_t                     major_start;
    coord_t                     minor_start;
    coord_t                     major_stop;
    logic signed [DEC_BITS-1:0] decision;
    logic        [INC_BITS-1:0] inc_stay;
    logic signed [INC_BITS-1:0] inc_move;
    logic                       single;
  } line_setup_t;

endpackage

`default_nettype wire

// File: rtl/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): a start transaction
// (kind = start) carries two endpoints and emits the first pixel of the line;
// each step transaction emits the next pixel. A step while no line is active
// is consumed and gives no pixel. A start during a line drops that line.
// Output channel (out_valid_o / out_stall_i / out_item_o): one pixel per
// productive transaction, with last set on the far endpoint.
// Throughput: one transaction per cycle while out_stall_i is low, set by the
// single add-and-compare step between the input and pixel registers.
// Path: an accepted transaction waits in the input register and its pixel
// is written to the pixel register once that register is free.
// Reset: asynchronous and active low; no line is active and both registers
// are empty afterwards.
// Stall: a stalled pixel holds in the output register; the input register
// still takes a new transaction when it is empty or the output register is
// free or being taken, otherwise in_stall_o rises the same cycle.
`default_nettype none

module bresenham_line_rasterizer (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire blr_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output blr_pkg::out_item_t      out_item_o
);
  import blr_pkg::*;

`include "bresenham_line_rasterizer_assert.svh"

  // Input register
  logic     in_valid_q;
  in_item_t in_item_q;

  // Line state
  logic                       active_q, active_d;
  logic                       steep_q, steep_d;
  logic                       minor_down_q, minor_down_d;
  coord_t                     major_pos_q, major_pos_d;
  coord_t                     minor_pos_q, minor_pos_d;
  coord_t                     major_stop_q, major_stop_d;
  logic signed [DEC_BITS-1:0] decision_q, decision_d;
  logic        [INC_BITS-1:0] inc_stay_q, inc_stay_d;
  logic signed [INC_BITS-1:0] inc_move_q, inc_move_d;

  // Output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  line_setup_t setup;
  logic        out_free;
  logic        fire;

  blr_setup u_setup (
    .item_i  (in_item_q),
    .setup_o (setup)
  );

  // Process the held transaction whenever the pixel register can take a result.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_comb begin
    coord_t major_next;
    coord_t minor_next;
    logic   is_last;

    active_d     = active_q;
    steep_d      = steep_q;
    minor_down_d = minor_down_q;
    major_pos_d  = major_pos_q;
    minor_pos_d  = minor_pos_q;
    major_stop_d = major_stop_q;
    decision_d   = decision_q;
    inc_stay_d   = inc_stay_q;
    inc_move_d   = inc_move_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_item_d   = out_item_q;
    major_next   = major_pos_q + coord_t'(1);
    minor_next   = minor_pos_q;
    is_last      = 1'b0;

    if (fire) begin
      unique case (in_item_q.kind)
        KIND_START: begin
          // Load the new line and show its first pixel.
          steep_d      = setup.steep;
          minor_down_d = setup.minor_down;
          major_pos_d  = setup.major_start;
          minor_pos_d  = setup.minor_start;
          major_stop_d = setup.major_stop;
          decision_d   = setup.decision;
          inc_stay_d   = setup.inc_stay;
          inc_move_d   = setup.inc_move;
          active_d     = !setup.single;
          out_valid_d  = 1'b1;
          out_item_d.pixel_x = setup.steep ? setup.minor_start : setup.major_start;
          out_item_d.pixel_y = setup.steep ? setup.major_start : setup.minor_start;
          out_item_d.last    = setup.single;
        end
        KIND_STEP: begin
          if (active_q) begin
            // Advance the major axis; move the minor axis on a non-negative term.
            if (decision_q[DEC_BITS-1]) begin
              decision_d = decision_q + $signed({1'b0, inc_stay_q});
            end else begin
              minor_next = minor_down_q ? minor_pos_q - coord_t'(1)
                                        : minor_pos_q + coord_t'(1);
              decision_d = decision_q + DEC_BITS'(inc_move_q);
            end
            is_last      = major_next == major_stop_q;
            major_pos_d  = major_next;
            minor_pos_d  = minor_next;
            active_d     = !is_last;
            out_valid_d  = 1'b1;
            out_item_d.pixel_x = steep_q ? minor_next : major_next;
            out_item_d.pixel_y = steep_q ? major_next : minor_next;
            out_item_d.last    = is_last;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      steep_q      <= 1'b0;
      minor_down_q <= 1'b0;
      major_pos_q  <= '0;
      minor_pos_q  <= '0;
      major_stop_q <= '0;
      decision_q   <= '0;
      inc_stay_q   <= '0;
      inc_move_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      active_q     <= active_d;
      steep_q      <= steep_d;
      minor_down_q <= minor_down_d;
      major_pos_q  <= major_pos_d;
      minor_pos_q  <= minor_pos_d;
      major_stop_q <= major_stop_d;
      decision_q   <= decision_d;
      inc_stay_q   <= inc_stay_d;
      inc_move_q   <= inc_move_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A step with no line leaves the pixel register empty.
  `BLR_ASSERT_NEXT(a_idle_step_silent, clk_i, rst_ni,
    fire && in_item_q.kind == KIND_STEP && !active_q, !out_valid_o,
    "step without an active line produced a pixel")
  // A start always shows a pixel, flagged last exactly when no line stays active.
  `BLR_ASSERT_NEXT(a_start_pixel, clk_i, rst_ni,
    fire && in_item_q.kind == KIND_START,
    out_valid_o && (out_item_o.last == !active_q),
    "start pixel and line state disagree")
  // A step on an active line shows a pixel; last ends the line.
  `BLR_ASSERT_NEXT(a_step_pixel, clk_i, rst_ni,
    fire && in_item_q.kind == KIND_STEP && active_q,
    out_valid_o && (out_item_o.last == !active_q),
    "step pixel and line state disagree")

endmodule

`default_nettype wire

// File: rtl/blr_setup.sv
// Line set-up: major axis choice, endpoint ordering and initial decision terms.
`default_nettype none

module blr_setup (
  input  wire blr_pkg::in_item_t item_i,
  output blr_pkg::line_setup_t   setup_o
);
  import blr_pkg::*;

  coord_t dx, dy;
  coord_t smaj, smin, emaj, emin;
  coord_t dmaj, dmin;
  logic   steep;
  logic   swap;

  assign dx    = (item_i.end_x > item_i.start_x) ? item_i.end_x - item_i.start_x
                                                 : item_i.start_x - item_i.end_x;
  assign dy    = (item_i.end_y > item_i.start_y) ? item_i.end_y - item_i.start_y
                                                 : item_i.start_y - item_i.end_y;
  assign steep = dy > dx;
  assign dmaj  = steep ? dy : dx;
  assign dmin  = steep ? dx : dy;

  always_comb begin
    coord_t amaj, amin, bmaj, bmin;
    amaj = steep ? item_i.start_y : item_i.start_x;
    amin = steep ? item_i.start_x : item_i.start_y;
    bmaj = steep ? item_i.end_y   : item_i.end_x;
    bmin = steep ? item_i.end_x   : item_i.end_y;
    swap = amaj > bmaj;
    smaj = swap ? bmaj : amaj;
    smin = swap ? bmin : amin;
    emaj = swap ? amaj : bmaj;
    emin = swap ? amin : bmin;
  end

  always_comb begin
    setup_o.steep       = steep;
    setup_o.minor_down  = emin < smin;
    setup_o.major_start = smaj;
    setup_o.minor_start = smin;
    setup_o.major_stop  = emaj;
    // 2*dminor - dmajor
    setup_o.decision    = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
    setup_o.inc_stay    = {1'b0, dmin, 1'b0};
    setup_o.inc_move    = $signed({1'b0, dmin, 1'b0}) - $signed({1'b0, dmaj, 1'b0});
    setup_o.single      = smaj == emaj;
  end

endmodule

`default_nettype wire
